// ----- rtl/gstc_pkg.sv -----
// Shared types and constants for the graph edge table / spanning tree counter.
// No dependencies; imported by gstc_mac, graph_edge_table_spanning_tree_count and the testbench.
package gstc_pkg;

    localparam int VAL_W    = 64;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int HALF_W   = VAL_W / 2;
    localparam int ANSWER_W = 27;
    localparam int DIV_CW   = $clog2(VAL_W);

    localparam logic [ANSWER_W-1:0] ANSWER_MAX = {ANSWER_W{1'b1}};
    localparam logic [VAL_W-1:0]    PROD_LIMIT = 64'h4000_0000_0000_0000;

    localparam logic [2:0] KIND_ADD_EDGE   = 3'd0;
    localparam logic [2:0] KIND_CLEAR      = 3'd1;
    localparam logic [2:0] KIND_SET_COUNT  = 3'd2;
    localparam logic [2:0] KIND_COMPLETE   = 3'd3;
    localparam logic [2:0] KIND_DEGREE     = 3'd4;
    localparam logic [2:0] KIND_ADJACENCY  = 3'd5;
    localparam logic [2:0] KIND_TREE_COUNT = 3'd6;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_PAIR  = 3'd1;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
    localparam logic [2:0] STATUS_BAD_INDEX = 3'd3;
    localparam logic [2:0] STATUS_NO_EDGES  = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_CPL,
        ST_DEG,
        ST_ADJ,
        ST_SCAN,
        ST_SCAN_END,
        ST_BUILD,
        ST_K_START,
        ST_K_PIV,
        ST_K_SRCH,
        ST_SW_RDK,
        ST_SW_RDR,
        ST_SW_WRK,
        ST_SW_WRR,
        ST_ROW_START,
        ST_ROW_AIK,
        ST_EL_KJ,
        ST_EL_IJ,
        ST_EL_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MAC_IDLE,
        MAC_MUL,
        MAC_FIX,
        MAC_SUB,
        MAC_DIV,
        MAC_DONE
    } mac_state_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } mac_status_t;

endpackage

// ----- rtl/gstc_mac.sv -----
// Multi-cycle fraction-free update unit: (x*y - u*w) / d with overflow flag.
// Shared 32x32 multiplier over four partial products, bit-serial divider.
// Depends on gstc_pkg.
module gstc_mac (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [gstc_pkg::VAL_W-1:0] op_x,
    input  logic signed [gstc_pkg::VAL_W-1:0] op_y,
    input  logic signed [gstc_pkg::VAL_W-1:0] op_u,
    input  logic signed [gstc_pkg::VAL_W-1:0] op_w,
    input  logic signed [gstc_pkg::VAL_W-1:0] op_d,
    output logic signed [gstc_pkg::VAL_W-1:0] result,
    output gstc_pkg::mac_status_t           status
);
    import gstc_pkg::*;

    mac_state_t               state_reg, state_next;
    logic                     pair_reg, pair_next;
    logic [1:0]               pp_cnt_reg, pp_cnt_next;
    logic [PROD_W-1:0]        acc_reg, acc_next;
    logic [VAL_W-1:0]         ma1_reg, ma1_next;
    logic [VAL_W-1:0]         mb_reg, mb_next;
    logic                     zero_reg, zero_next;
    logic                     sgn_reg, sgn_next;
    logic                     ovf_reg, ovf_next;
    logic signed [VAL_W-1:0]  p_reg, p_next;
    logic signed [VAL_W-1:0]  q_reg, q_next;
    logic [VAL_W-1:0]         num_reg, num_next;
    logic [VAL_W-1:0]         den_reg, den_next;
    logic [VAL_W:0]           rem_reg, rem_next;
    logic                     qneg_reg, qneg_next;
    logic [DIV_CW-1:0]        cnt_reg, cnt_next;

    logic [HALF_W-1:0]        pa, pb;
    logic [VAL_W-1:0]         pp;
    logic [PROD_W-1:0]        pp_shift;
    logic [VAL_W-1:0]         mag;
    logic signed [VAL_W-1:0]  prod;
    logic signed [VAL_W-1:0]  diff;
    logic [VAL_W:0]           rem_shift;
    logic                     ovf_now;
    logic [VAL_W-1:0]         abs_a, abs_b;

    function automatic logic [VAL_W-1:0] mag_of(input logic signed [VAL_W-1:0] v);
        mag_of = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    endfunction

    assign result = qneg_reg ? -$signed(num_reg) : $signed(num_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MAC_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pair_reg   <= pair_next;
        pp_cnt_reg <= pp_cnt_next;
        acc_reg    <= acc_next;
        ma1_reg    <= ma1_next;
        mb_reg     <= mb_next;
        zero_reg   <= zero_next;
        sgn_reg    <= sgn_next;
        ovf_reg    <= ovf_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        qneg_reg   <= qneg_next;
        cnt_reg    <= cnt_next;
    end

    always_comb begin
        state_next  = state_reg;
        pair_next   = pair_reg;
        pp_cnt_next = pp_cnt_reg;
        acc_next    = acc_reg;
        ma1_next    = ma1_reg;
        mb_next     = mb_reg;
        zero_next   = zero_reg;
        sgn_next    = sgn_reg;
        ovf_next    = ovf_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        qneg_next   = qneg_reg;
        cnt_next    = cnt_reg;
        status      = '0;

        pa = pp_cnt_reg[1] ? ma1_reg[VAL_W-1:HALF_W] : ma1_reg[HALF_W-1:0];
        pb = pp_cnt_reg[0] ? mb_reg[VAL_W-1:HALF_W]  : mb_reg[HALF_W-1:0];
        pp = VAL_W'(pa) * VAL_W'(pb);
        case (pp_cnt_reg)
            2'd0:    pp_shift = PROD_W'(pp);
            2'd3:    pp_shift = PROD_W'(pp) << VAL_W;
            default: pp_shift = PROD_W'(pp) << HALF_W;
        endcase

        // (|a|+1)*|b| above the limit marks overflow; |a*b| is that minus |b|
        ovf_now = !zero_reg && (acc_reg > PROD_W'(PROD_LIMIT));
        mag     = acc_reg[VAL_W-1:0] - mb_reg;
        if (zero_reg) begin
            prod = '0;
        end else begin
            prod = sgn_reg ? -$signed(mag) : $signed(mag);
        end
        diff = p_reg - q_reg;
        rem_shift = {rem_reg[VAL_W-1:0], num_reg[VAL_W-1]};

        abs_a = mag_of(pair_reg ? op_u : op_x);
        abs_b = mag_of(pair_reg ? op_w : op_y);

        case (state_reg)
            MAC_IDLE: begin
                if (start) begin
                    pair_next   = 1'b0;
                    ovf_next    = 1'b0;
                    abs_a       = mag_of(op_x);
                    abs_b       = mag_of(op_y);
                    ma1_next    = abs_a + VAL_W'(1);
                    mb_next     = abs_b;
                    zero_next   = (abs_a == '0) || (abs_b == '0);
                    sgn_next    = op_x[VAL_W-1] ^ op_y[VAL_W-1];
                    acc_next    = '0;
                    pp_cnt_next = '0;
                    state_next  = MAC_MUL;
                end
            end
            MAC_MUL: begin
                acc_next    = acc_reg + pp_shift;
                pp_cnt_next = pp_cnt_reg + 2'd1;
                if (pp_cnt_reg == 2'd3) begin
                    state_next = MAC_FIX;
                end
            end
            MAC_FIX: begin
                ovf_next = ovf_reg | ovf_now;
                if (!pair_reg) begin
                    p_next      = prod;
                    pair_next   = 1'b1;
                    abs_a       = mag_of(op_u);
                    abs_b       = mag_of(op_w);
                    ma1_next    = abs_a + VAL_W'(1);
                    mb_next     = abs_b;
                    zero_next   = (abs_a == '0) || (abs_b == '0);
                    sgn_next    = op_u[VAL_W-1] ^ op_w[VAL_W-1];
                    acc_next    = '0;
                    pp_cnt_next = '0;
                    state_next  = MAC_MUL;
                end else begin
                    q_next     = prod;
                    state_next = MAC_SUB;
                end
            end
            MAC_SUB: begin
                if (ovf_reg) begin
                    state_next = MAC_DONE;
                end else begin
                    num_next   = mag_of(diff);
                    den_next   = mag_of(op_d);
                    qneg_next  = diff[VAL_W-1] ^ op_d[VAL_W-1];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = MAC_DIV;
                end
            end
            MAC_DIV: begin
                if (rem_shift >= {1'b0, den_reg}) begin
                    rem_next = rem_shift - {1'b0, den_reg};
                    num_next = {num_reg[VAL_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift;
                    num_next = {num_reg[VAL_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(VAL_W - 1)) begin
                    state_next = MAC_DONE;
                end
            end
            MAC_DONE: begin
                status.done = 1'b1;
                status.ovf  = ovf_reg;
                state_next  = MAC_IDLE;
            end
            default: begin
                state_next = MAC_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/graph_edge_table_spanning_tree_count.sv -----
// Top level: graph adjacency store, command sequencer and Laplacian minor memory.
// Depends on gstc_pkg and gstc_mac. Reset: adjacency rows cleared at once through per-row
//   valid bits; no clearing pass. One command at a time, the next accepted once its result is registered.
// Tree count: row scan, m*m fill of the Laplacian minor, then fraction-free elimination with
//   one gstc_mac update per entry; the minor is at most nine by nine.
module graph_edge_table_spanning_tree_count #(
    parameter int MAX_VERTICES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // vertex_a[3:0], vertex_b[7:4], new_vertex_count[11:8]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[2:0], is_adjacent[3], answer_value[30:4],
                                   // edge_total[36:31], vertex_total[40:37]
);
    import gstc_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int MD  = MAX_VERTICES - 1;
    localparam int IW  = $clog2(MD);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int ECW = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
    localparam int MAT_DEPTH = 2 ** (2 * IW);

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [VAL_W-1:0]        mat_mem [MAT_DEPTH];

    state_t                  state_reg, state_next;
    logic [2:0]              kind_reg, kind_next;
    logic [3:0]              va_reg, va_next;
    logic [3:0]              vb_reg, vb_next;
    logic [3:0]              nc_reg, nc_next;
    logic [MAX_VERTICES-1:0] valid_reg, valid_next;
    logic [ECW-1:0]          edges_reg, edges_next;
    logic [VCW-1:0]          vc_reg, vc_next;
    logic [2:0]              status_reg, status_next;
    logic                    adj_bit_reg, adj_bit_next;
    logic [ANSWER_W-1:0]     answer_reg, answer_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           lo_reg, lo_next;
    logic [AW-1:0]           hi_reg, hi_next;
    logic                    found_reg, found_next;
    logic [IW-1:0]           mlast_reg, mlast_next;
    logic [IW-1:0]           k_reg, k_next;
    logic [IW-1:0]           i_reg, i_next;
    logic [IW-1:0]           j_reg, j_next;
    logic [IW-1:0]           r_reg, r_next;
    logic                    neg_reg, neg_next;
    logic signed [VAL_W-1:0] pivot_reg, pivot_next;
    logic signed [VAL_W-1:0] prev_reg, prev_next;
    logic signed [VAL_W-1:0] aik_reg, aik_next;
    logic signed [VAL_W-1:0] akj_reg, akj_next;
    logic [VAL_W-1:0]        tmp_reg, tmp_next;
    logic                    out_valid_reg, out_valid_next;
    logic [47:0]             out_data_reg, out_data_next;

    logic                    adj_re, adj_we;
    logic [AW-1:0]           adj_raddr, adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] adj_rdata_reg;
    logic                    adj_rvalid_reg;
    logic                    mat_re, mat_we;
    logic [2*IW-1:0]         mat_raddr, mat_waddr;
    logic [VAL_W-1:0]        mat_wdata;
    logic signed [VAL_W-1:0] mat_rdata_reg;

    logic                    mac_start;
    logic signed [VAL_W-1:0] mac_result;
    mac_status_t             mac_status;

    logic [MAX_VERTICES-1:0] row;
    logic [MAX_VERTICES-1:0] shifted;
    logic [MAX_VERTICES-1:0] one_hot;
    logic [MAX_VERTICES:0]   low_mask;
    logic [AW-1:0]           vj;
    logic [AW-1:0]           deg;
    logic [4:0]              va_ext, vb_ext, nc_ext, vc_ext;
    logic [4:0]              grow;
    logic signed [VAL_W-1:0] det;

    gstc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .op_x    (mat_rdata_reg),
        .op_y    (pivot_reg),
        .op_u    (aik_reg),
        .op_w    (akj_reg),
        .op_d    (prev_reg),
        .result  (mac_result),
        .status  (mac_status)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            adj_rdata_reg <= adj_mem[adj_raddr];
        end
        if (mat_we) begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        if (mat_re) begin
            mat_rdata_reg <= mat_mem[mat_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            edges_reg      <= '0;
            vc_reg         <= '0;
            out_valid_reg  <= 1'b0;
            adj_rvalid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            edges_reg     <= edges_next;
            vc_reg        <= vc_next;
            out_valid_reg <= out_valid_next;
            if (adj_re) begin
                adj_rvalid_reg <= valid_reg[adj_raddr];
            end
        end
        kind_reg     <= kind_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        nc_reg       <= nc_next;
        status_reg   <= status_next;
        adj_bit_reg  <= adj_bit_next;
        answer_reg   <= answer_next;
        idx_reg      <= idx_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        found_reg    <= found_next;
        mlast_reg    <= mlast_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        r_reg        <= r_next;
        neg_reg      <= neg_next;
        pivot_reg    <= pivot_next;
        prev_reg     <= prev_next;
        aik_reg      <= aik_next;
        akj_reg      <= akj_next;
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        nc_next        = nc_reg;
        valid_next     = valid_reg;
        edges_next     = edges_reg;
        vc_next        = vc_reg;
        status_next    = status_reg;
        adj_bit_next   = adj_bit_reg;
        answer_next    = answer_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        found_next     = found_reg;
        mlast_next     = mlast_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        neg_next       = neg_reg;
        pivot_next     = pivot_reg;
        prev_next      = prev_reg;
        aik_next       = aik_reg;
        akj_next       = akj_reg;
        tmp_next       = tmp_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        adj_re    = 1'b0;
        adj_we    = 1'b0;
        adj_raddr = '0;
        adj_waddr = '0;
        adj_wdata = '0;
        mat_re    = 1'b0;
        mat_we    = 1'b0;
        mat_raddr = '0;
        mat_waddr = '0;
        mat_wdata = '0;
        mac_start = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        row      = adj_rvalid_reg ? adj_rdata_reg : '0;
        va_ext   = {1'b0, va_reg};
        vb_ext   = {1'b0, vb_reg};
        nc_ext   = {1'b0, nc_reg};
        vc_ext   = 5'(vc_reg);
        one_hot  = '0;
        shifted  = '0;
        low_mask = ((MAX_VERTICES + 1)'(1) << vc_reg) - (MAX_VERTICES + 1)'(1);
        vj       = AW'({1'b0, lo_reg} + (AW + 1)'(j_reg) + (AW + 1)'(1));
        deg      = AW'($countones(row));
        grow     = '0;
        det      = neg_reg ? -mat_rdata_reg : mat_rdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    va_next    = s_tdata[3:0];
                    vb_next    = s_tdata[7:4];
                    nc_next    = s_tdata[11:8];
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                status_next  = STATUS_OK;
                adj_bit_next = 1'b0;
                answer_next  = '0;
                state_next   = ST_FINISH;
                case (kind_reg)
                    KIND_ADD_EDGE: begin
                        if (va_reg == vb_reg || va_ext >= 5'(MAX_VERTICES)
                                || vb_ext >= 5'(MAX_VERTICES)) begin
                            status_next = STATUS_BAD_PAIR;
                        end else begin
                            adj_re     = 1'b1;
                            adj_raddr  = AW'(va_reg);
                            state_next = ST_EDGE_A;
                        end
                    end
                    KIND_CLEAR: begin
                        valid_next = '0;
                        edges_next = '0;
                    end
                    KIND_SET_COUNT: begin
                        if (nc_ext > 5'(MAX_VERTICES)) begin
                            status_next = STATUS_BAD_PAIR;
                        end else begin
                            valid_next = '0;
                            edges_next = '0;
                            vc_next    = VCW'(nc_reg);
                        end
                    end
                    KIND_COMPLETE: begin
                        valid_next = '0;
                        edges_next = '0;
                        idx_next   = '0;
                        state_next = ST_CPL;
                    end
                    KIND_DEGREE: begin
                        if (va_ext >= vc_ext) begin
                            status_next = STATUS_BAD_INDEX;
                        end else begin
                            adj_re     = 1'b1;
                            adj_raddr  = AW'(va_reg);
                            state_next = ST_DEG;
                        end
                    end
                    KIND_ADJACENCY: begin
                        if (va_ext >= vc_ext || vb_ext >= vc_ext) begin
                            status_next = STATUS_BAD_INDEX;
                        end else begin
                            adj_re     = 1'b1;
                            adj_raddr  = AW'(va_reg);
                            state_next = ST_ADJ;
                        end
                    end
                    KIND_TREE_COUNT: begin
                        if (edges_reg == '0) begin
                            status_next = STATUS_NO_EDGES;
                        end else begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            lo_next    = '0;
                            hi_next    = '0;
                            adj_re     = 1'b1;
                            adj_raddr  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_EDGE_A: begin
                shifted = row >> vb_reg;
                if (shifted[0]) begin
                    status_next = STATUS_DUPLICATE;
                    state_next  = ST_FINISH;
                end else begin
                    one_hot    = MAX_VERTICES'(1) << vb_reg;
                    adj_we     = 1'b1;
                    adj_waddr  = AW'(va_reg);
                    adj_wdata  = row | one_hot;
                    valid_next[AW'(va_reg)] = 1'b1;
                    adj_re     = 1'b1;
                    adj_raddr  = AW'(vb_reg);
                    state_next = ST_EDGE_B;
                end
            end
            ST_EDGE_B: begin
                one_hot   = MAX_VERTICES'(1) << va_reg;
                adj_we    = 1'b1;
                adj_waddr = AW'(vb_reg);
                adj_wdata = row | one_hot;
                valid_next[AW'(vb_reg)] = 1'b1;
                edges_next = edges_reg + ECW'(1);
                grow = (va_ext > vb_ext) ? va_ext + 5'd1 : vb_ext + 5'd1;
                if (grow > vc_ext) begin
                    vc_next = VCW'(grow);
                end
                state_next = ST_FINISH;
            end
            ST_CPL: begin
                one_hot   = MAX_VERTICES'(1) << idx_reg;
                adj_we    = 1'b1;
                adj_waddr = idx_reg;
                valid_next[idx_reg] = 1'b1;
                if (5'(idx_reg) < vc_ext) begin
                    adj_wdata  = MAX_VERTICES'(low_mask) & ~one_hot;
                    edges_next = edges_reg + ECW'(idx_reg);
                end
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(MAX_VERTICES - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_DEG: begin
                answer_next = ANSWER_W'(deg);
                state_next  = ST_FINISH;
            end
            ST_ADJ: begin
                shifted      = row >> vb_reg;
                adj_bit_next = shifted[0];
                state_next   = ST_FINISH;
            end
            ST_SCAN: begin
                if (row != '0) begin
                    if (!found_reg) begin
                        lo_next = idx_reg;
                    end
                    found_next = 1'b1;
                    hi_next    = idx_reg;
                end
                if (idx_reg == AW'(MAX_VERTICES - 1)) begin
                    state_next = ST_SCAN_END;
                end else begin
                    idx_next  = idx_reg + AW'(1);
                    adj_re    = 1'b1;
                    adj_raddr = idx_reg + AW'(1);
                end
            end
            ST_SCAN_END: begin
                if (!found_reg || hi_reg <= lo_reg) begin
                    status_next = STATUS_NO_EDGES;
                    state_next  = ST_FINISH;
                end else begin
                    mlast_next = IW'(hi_reg - lo_reg - AW'(1));
                    i_next     = '0;
                    j_next     = '0;
                    adj_re     = 1'b1;
                    adj_raddr  = lo_reg + AW'(1);
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD: begin
                shifted   = row >> vj;
                mat_we    = 1'b1;
                mat_waddr = {i_reg, j_reg};
                if (i_reg == j_reg) begin
                    mat_wdata = VAL_W'(deg);
                end else begin
                    mat_wdata = shifted[0] ? {VAL_W{1'b1}} : '0;
                end
                j_next = j_reg + IW'(1);
                if (j_reg == mlast_reg) begin
                    j_next = '0;
                    if (i_reg == mlast_reg) begin
                        k_next     = '0;
                        neg_next   = 1'b0;
                        prev_next  = VAL_W'(1);
                        state_next = ST_K_START;
                    end else begin
                        i_next    = i_reg + IW'(1);
                        adj_re    = 1'b1;
                        adj_raddr = AW'({1'b0, lo_reg} + (AW + 1)'(i_reg) + (AW + 1)'(2));
                    end
                end
            end
            ST_K_START: begin
                mat_re     = 1'b1;
                mat_raddr  = {k_reg, k_reg};
                state_next = ST_K_PIV;
            end
            ST_K_PIV: begin
                if (mat_rdata_reg != '0) begin
                    if (k_reg == mlast_reg) begin
                        if (det < 0) begin
                            answer_next = '0;
                        end else if (det > $signed({{(VAL_W - ANSWER_W){1'b0}}, ANSWER_MAX}))
                                begin
                            answer_next = ANSWER_MAX;
                        end else begin
                            answer_next = det[ANSWER_W-1:0];
                        end
                        state_next = ST_FINISH;
                    end else begin
                        pivot_next = mat_rdata_reg;
                        i_next     = k_reg + IW'(1);
                        state_next = ST_ROW_START;
                    end
                end else if (k_reg == mlast_reg) begin
                    answer_next = '0;
                    state_next  = ST_FINISH;
                end else begin
                    r_next     = k_reg + IW'(1);
                    mat_re     = 1'b1;
                    mat_raddr  = {k_reg + IW'(1), k_reg};
                    state_next = ST_K_SRCH;
                end
            end
            ST_K_SRCH: begin
                if (mat_rdata_reg != '0) begin
                    j_next     = '0;
                    state_next = ST_SW_RDK;
                end else if (r_reg == mlast_reg) begin
                    answer_next = '0;
                    state_next  = ST_FINISH;
                end else begin
                    r_next    = r_reg + IW'(1);
                    mat_re    = 1'b1;
                    mat_raddr = {r_reg + IW'(1), k_reg};
                end
            end
            ST_SW_RDK: begin
                mat_re     = 1'b1;
                mat_raddr  = {k_reg, j_reg};
                state_next = ST_SW_RDR;
            end
            ST_SW_RDR: begin
                tmp_next   = mat_rdata_reg;
                mat_re     = 1'b1;
                mat_raddr  = {r_reg, j_reg};
                state_next = ST_SW_WRK;
            end
            ST_SW_WRK: begin
                mat_we     = 1'b1;
                mat_waddr  = {k_reg, j_reg};
                mat_wdata  = mat_rdata_reg;
                state_next = ST_SW_WRR;
            end
            ST_SW_WRR: begin
                mat_we    = 1'b1;
                mat_waddr = {r_reg, j_reg};
                mat_wdata = tmp_reg;
                if (j_reg == mlast_reg) begin
                    neg_next   = !neg_reg;
                    state_next = ST_K_START;
                end else begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_SW_RDK;
                end
            end
            ST_ROW_START: begin
                mat_re     = 1'b1;
                mat_raddr  = {i_reg, k_reg};
                state_next = ST_ROW_AIK;
            end
            ST_ROW_AIK: begin
                aik_next   = mat_rdata_reg;
                j_next     = k_reg + IW'(1);
                mat_re     = 1'b1;
                mat_raddr  = {k_reg, k_reg + IW'(1)};
                state_next = ST_EL_KJ;
            end
            ST_EL_KJ: begin
                akj_next   = mat_rdata_reg;
                mat_re     = 1'b1;
                mat_raddr  = {i_reg, j_reg};
                state_next = ST_EL_IJ;
            end
            ST_EL_IJ: begin
                mac_start  = 1'b1;
                state_next = ST_EL_WAIT;
            end
            ST_EL_WAIT: begin
                if (mac_status.done) begin
                    if (mac_status.ovf) begin
                        answer_next = ANSWER_MAX;
                        state_next  = ST_FINISH;
                    end else begin
                        mat_we    = 1'b1;
                        mat_waddr = {i_reg, j_reg};
                        mat_wdata = mac_result;
                        if (j_reg == mlast_reg) begin
                            if (i_reg == mlast_reg) begin
                                prev_next  = pivot_reg;
                                k_next     = k_reg + IW'(1);
                                state_next = ST_K_START;
                            end else begin
                                i_next     = i_reg + IW'(1);
                                state_next = ST_ROW_START;
                            end
                        end else begin
                            j_next     = j_reg + IW'(1);
                            mat_re     = 1'b1;
                            mat_raddr  = {k_reg, j_reg + IW'(1)};
                            state_next = ST_EL_KJ;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, 4'(vc_reg), 6'(edges_reg), answer_reg,
                                      adj_bit_reg, status_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- bench/tb_graph_edge_table_spanning_tree_count.sv -----
// Testbench for graph_edge_table_spanning_tree_count: directed command table, then random
// graph-building sequences, each result checked against an in-bench graph and tree-count model.
// Depends on gstc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_graph_edge_table_spanning_tree_count;
    import gstc_pkg::*;

    localparam int NV = 10;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [2:0] KIND_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [3:0]  vertex_total;
        logic [5:0]  edge_total;
        logic [26:0] answer_value;
        logic        is_adjacent;
        logic [2:0]  status;
    } graph_reply_t;

    typedef struct {
        logic [2:0] kind;
        logic [3:0] va;
        logic [3:0] vb;
        logic [3:0] nc;
        bit         fixed;
        logic [2:0] status;
        logic [26:0] answer;
    } cmd_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    graph_edge_table_spanning_tree_count #(.MAX_VERTICES(NV)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // graph model
    logic [NV-1:0] adj_row [NV];
    int            deg [NV];
    int            n_edges;
    int            n_verts;

    graph_reply_t  reply_q [$];
    int            errors;
    int            idle_pct_s;
    int            idle_pct_m;
    int            quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void wipe_edges();
        for (int i = 0; i < NV; i++) begin
            adj_row[i] = '0;
            deg[i] = 0;
        end
        n_edges = 0;
    endfunction

    function automatic void link(int a, int b);
        adj_row[a][b] = 1'b1;
        adj_row[b][a] = 1'b1;
        deg[a]++;
        deg[b]++;
        n_edges++;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Bareiss determinant of the reduced Laplacian, saturated like the block
    function automatic logic [26:0] model_tree_count(output logic [2:0] st);
        longint mx [NV][NV];
        longint prev, det, p, q, t;
        int lo, hi, m, r;
        bit neg, ovf;
        longint unsigned ma, mb;
        lo = -1;
        hi = -1;
        neg = 0;
        ovf = 0;
        prev = 1;
        st = STATUS_OK;
        if (n_edges == 0) begin
            st = STATUS_NO_EDGES;
            return '0;
        end
        for (int v = 0; v < NV; v++)
            if (deg[v] != 0) begin
                if (lo < 0) lo = v;
                hi = v;
            end
        if (lo < 0 || hi <= lo) begin
            st = STATUS_NO_EDGES;
            return '0;
        end
        m = hi - lo;
        for (int i = 0; i < m; i++)
            for (int j = 0; j < m; j++)
                mx[i][j] = (i == j) ? deg[lo+1+i] : (adj_row[lo+1+i][lo+1+j] ? -1 : 0);
        for (int k = 0; k < m; k++) begin
            if (mx[k][k] == 0) begin
                r = k + 1;
                while (r < m && mx[r][k] == 0) r++;
                if (r >= m) return '0;
                for (int j = 0; j < m; j++) begin
                    t = mx[k][j];
                    mx[k][j] = mx[r][j];
                    mx[r][j] = t;
                end
                neg = !neg;
            end
            for (int i = k + 1; i < m; i++)
                for (int j = k + 1; j < m; j++) begin
                    p = 0;
                    q = 0;
                    ma = mag(mx[i][j]);
                    mb = mag(mx[k][k]);
                    if (ma != 0 && mb != 0) begin
                        if (ma >= 64'h4000_0000_0000_0000 / mb) ovf = 1;
                        else p = mx[i][j] * mx[k][k];
                    end
                    ma = mag(mx[i][k]);
                    mb = mag(mx[k][j]);
                    if (ma != 0 && mb != 0) begin
                        if (ma >= 64'h4000_0000_0000_0000 / mb) ovf = 1;
                        else q = mx[i][k] * mx[k][j];
                    end
                    if (ovf) return ANSWER_MAX;
                    mx[i][j] = (p - q) / prev;
                end
            prev = mx[k][k];
        end
        det = mx[m-1][m-1];
        if (neg) det = -det;
        if (det < 0) det = 0;
        if (det > 134217727) det = 134217727;
        return det[26:0];
    endfunction

    function automatic graph_reply_t apply_command(logic [2:0] kind, logic [3:0] a,
                                                   logic [3:0] b, logic [3:0] nc);
        graph_reply_t rp;
        logic [2:0] st;
        rp = '0;
        case (kind)
            KIND_ADD_EDGE: begin
                if (a == b || a >= NV || b >= NV) rp.status = STATUS_BAD_PAIR;
                else if (adj_row[a][b]) rp.status = STATUS_DUPLICATE;
                else begin
                    link(a, b);
                    if (a + 1 > n_verts) n_verts = a + 1;
                    if (b + 1 > n_verts) n_verts = b + 1;
                end
            end
            KIND_CLEAR: wipe_edges();
            KIND_SET_COUNT: begin
                if (nc > NV) rp.status = STATUS_BAD_PAIR;
                else begin
                    wipe_edges();
                    n_verts = nc;
                end
            end
            KIND_COMPLETE: begin
                wipe_edges();
                for (int i = 0; i < n_verts; i++)
                    for (int j = i + 1; j < n_verts; j++) link(i, j);
            end
            KIND_DEGREE: begin
                if (a >= n_verts) rp.status = STATUS_BAD_INDEX;
                else rp.answer_value = deg[a];
            end
            KIND_ADJACENCY: begin
                if (a >= n_verts || b >= n_verts) rp.status = STATUS_BAD_INDEX;
                else rp.is_adjacent = adj_row[a][b];
            end
            KIND_TREE_COUNT: begin
                rp.answer_value = model_tree_count(st);
                rp.status = st;
            end
            default: ;
        endcase
        rp.edge_total = n_edges[5:0];
        rp.vertex_total = n_verts[3:0];
        return rp;
    endfunction

    task automatic send_command(logic [2:0] kind, logic [3:0] a, logic [3:0] b,
                                logic [3:0] nc, output graph_reply_t rp);
        while ($urandom_range(99) < idle_pct_s) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        rp = apply_command(kind, a, b, nc);
        reply_q.push_back(rp);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'h0, nc, b, a};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reply_q.size() != 0) @(posedge aclk);
    endtask

    // receiver with random stall
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= idle_pct_m);
    end

    always @(posedge aclk) begin
        graph_reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[40:0];
            if (reply_q.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.is_adjacent !== want.is_adjacent) begin
                    $error("is_adjacent exp %0d got %0d", want.is_adjacent, got.is_adjacent);
                    errors++;
                end
                if (got.answer_value !== want.answer_value) begin
                    $error("answer_value exp %0d got %0d", want.answer_value,
                           got.answer_value);
                    errors++;
                end
                if (got.edge_total !== want.edge_total) begin
                    $error("edge_total exp %0d got %0d", want.edge_total, got.edge_total);
                    errors++;
                end
                if (got.vertex_total !== want.vertex_total) begin
                    $error("vertex_total exp %0d got %0d", want.vertex_total,
                           got.vertex_total);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** graph_edge_table_spanning_tree_count: FAILED **");
            $finish;
        end
    end

    cmd_row_t cmd_table [] = '{
        '{KIND_DEGREE,     4'd0,  4'd0,  4'd0,  1, STATUS_BAD_INDEX, 27'd0},
        '{KIND_TREE_COUNT, 4'd0,  4'd0,  4'd0,  1, STATUS_NO_EDGES,  27'd0},
        '{KIND_ADD_EDGE,   4'd3,  4'd3,  4'd0,  1, STATUS_BAD_PAIR,  27'd0},
        '{KIND_ADD_EDGE,   4'd15, 4'd0,  4'd0,  1, STATUS_BAD_PAIR,  27'd0},
        '{KIND_ADD_EDGE,   4'd0,  4'd10, 4'd0,  1, STATUS_BAD_PAIR,  27'd0},
        '{KIND_ADD_EDGE,   4'd0,  4'd9,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_ADD_EDGE,   4'd9,  4'd0,  4'd0,  1, STATUS_DUPLICATE, 27'd0},
        '{KIND_ADJACENCY,  4'd9,  4'd0,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_ADJACENCY,  4'd4,  4'd4,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_ADJACENCY,  4'd15, 4'd0,  4'd0,  1, STATUS_BAD_INDEX, 27'd0},
        '{KIND_TREE_COUNT, 4'd0,  4'd0,  4'd0,  1, STATUS_OK,        27'd0},
        '{KIND_SET_COUNT,  4'd0,  4'd0,  4'd15, 1, STATUS_BAD_PAIR,  27'd0},
        '{KIND_SET_COUNT,  4'd0,  4'd0,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_COMPLETE,   4'd0,  4'd0,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_SET_COUNT,  4'd0,  4'd0,  4'd1,  0, STATUS_OK,        27'd0},
        '{KIND_COMPLETE,   4'd0,  4'd0,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_SET_COUNT,  4'd0,  4'd0,  4'd10, 0, STATUS_OK,        27'd0},
        '{KIND_COMPLETE,   4'd0,  4'd0,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_DEGREE,     4'd9,  4'd0,  4'd0,  1, STATUS_OK,        27'd9},
        '{KIND_TREE_COUNT, 4'd0,  4'd0,  4'd0,  1, STATUS_OK,        27'd100000000},
        '{KIND_CLEAR,      4'd0,  4'd0,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_ADD_EDGE,   4'd5,  4'd6,  4'd0,  0, STATUS_OK,        27'd0},
        '{KIND_TREE_COUNT, 4'd0,  4'd0,  4'd0,  1, STATUS_OK,        27'd1},
        '{KIND_UNKNOWN,    4'd15, 4'd15, 4'd15, 1, STATUS_OK,        27'd0}
    };

    initial begin
        graph_reply_t rp;
        logic [2:0] kind;
        int pick;
        errors = 0;
        idle_pct_s = 11;
        idle_pct_m = 47;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        wipe_edges();
        n_verts = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (cmd_table[i]) begin
            send_command(cmd_table[i].kind, cmd_table[i].va, cmd_table[i].vb,
                         cmd_table[i].nc, rp);
            if (cmd_table[i].fixed &&
                (rp.status !== cmd_table[i].status || rp.answer_value !== cmd_table[i].answer))
            begin
                $error("table row %0d: status exp %0d got %0d, answer_value exp %0d got %0d",
                       i, cmd_table[i].status, rp.status, cmd_table[i].answer,
                       rp.answer_value);
                errors++;
            end
        end
        wait_drained();

        for (int n = 0; n < 600; n++) begin
            if (n == 200) begin
                wait_drained();
                idle_pct_s = 47;
                idle_pct_m = 11;
            end else if (n == 400) begin
                wait_drained();
                idle_pct_s = 0;
                idle_pct_m = 0;
            end
            pick = $urandom_range(99);
            // half the commands are edge additions; most picks draw vertices from 0 to 9
            if (pick < 50) kind = KIND_ADD_EDGE;
            else if (pick < 60) kind = KIND_TREE_COUNT;
            else if (pick < 70) kind = KIND_DEGREE;
            else if (pick < 80) kind = KIND_ADJACENCY;
            else if (pick < 85) kind = KIND_SET_COUNT;
            else if (pick < 89) kind = KIND_CLEAR;
            else if (pick < 92) kind = KIND_COMPLETE;
            else kind = 3'($urandom_range(7));
            if ($urandom_range(9) == 0)
                send_command(kind, 4'($urandom_range(15)), 4'($urandom_range(15)),
                             4'($urandom_range(15)), rp);
            else
                send_command(kind, 4'($urandom_range(9)), 4'($urandom_range(9)),
                             4'($urandom_range(10)), rp);
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("** graph_edge_table_spanning_tree_count: PASSED **");
        else $display("** graph_edge_table_spanning_tree_count: FAILED **");
        $finish;
    end

endmodule

// ----- graph_edge_table_spanning_tree_count.f -----
rtl/gstc_pkg.sv
rtl/gstc_mac.sv
rtl/graph_edge_table_spanning_tree_count.sv
bench/tb_graph_edge_table_spanning_tree_count.sv
